// File: rtl/core/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: rtl/core/sitda_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sitda_pkg
// Shared constants and types for the signed integer to decimal ASCII block.
// ----------------------------------------------------------------------------
package sitda_pkg;

    localparam int VALUE_WIDTH_DEF = 32;

    // Magnitude bits consumed by the digit cells per clock
    localparam int BITS_PER_STEP = 4;

    localparam logic [6:0] ASCII_ZERO  = 7'd48;
    localparam logic [6:0] ASCII_NINE  = 7'd57;
    localparam logic [6:0] ASCII_MINUS = 7'd45;

    // Cell operations
    typedef enum logic [1:0] {
        OP_HOLD  = 2'd0,
        OP_CLEAR = 2'd1,
        OP_CONV  = 2'd2,
        OP_SHIFT = 2'd3
    } cell_op_t;

    // Decimal digits needed for 2^(width-1); log10(2) ~ 0.30103
    function automatic int num_digits(input int width);
        return ((width - 1) * 30103) / 100000 + 1;
    endfunction

endpackage

// File: rtl/core/sitda_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sitda_cell
// One BCD digit cell: shift-and-add-3 over four bits per clock, hold, clear,
// or shift its digit to the next cell up.
// ----------------------------------------------------------------------------
module sitda_cell (
    input  logic                                  aclk,
    input  sitda_pkg::cell_op_t                   op,
    input  logic [sitda_pkg::BITS_PER_STEP-1:0]   carry_in,
    input  logic [3:0]                            shift_in,
    output logic [sitda_pkg::BITS_PER_STEP-1:0]   carry_out,
    output logic [3:0]                            digit
);

    logic [3:0] digit_reg;
    logic [3:0] digit_next;
    logic [3:0] conv_val;

    // Bit BITS_PER_STEP-1 of carry_in is the first bit shifted in
    always_comb begin
        conv_val  = digit_reg;
        carry_out = '0;
        for (int j = 0; j < sitda_pkg::BITS_PER_STEP; j++) begin
            if (conv_val >= 4'd5) begin
                conv_val = conv_val + 4'd3;
            end
            carry_out[sitda_pkg::BITS_PER_STEP-1-j] = conv_val[3];
            conv_val = {conv_val[2:0], carry_in[sitda_pkg::BITS_PER_STEP-1-j]};
        end
    end

    always_comb begin
        unique case (op)
            sitda_pkg::OP_CLEAR: digit_next = 4'd0;
            sitda_pkg::OP_CONV:  digit_next = conv_val;
            sitda_pkg::OP_SHIFT: digit_next = shift_in;
            default:             digit_next = digit_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        digit_reg <= digit_next;
    end

    assign digit = digit_reg;

endmodule

// File: rtl/core/sitda_chain.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sitda_chain
// Row of digit cells, least significant at index 0, plus a scan for the
// highest nonzero digit.
// ----------------------------------------------------------------------------
module sitda_chain #(
    parameter int NDIG = 10,
    parameter int IDXW = 4
) (
    input  logic                                  aclk,
    input  sitda_pkg::cell_op_t                   op,
    input  logic [sitda_pkg::BITS_PER_STEP-1:0]   bits_in,
    output logic [NDIG-1:0][3:0]                  digits,
    output logic [IDXW-1:0]                       top_idx
);

    logic [sitda_pkg::BITS_PER_STEP-1:0] carry [NDIG+1];

    assign carry[0] = bits_in;

    for (genvar i = 0; i < NDIG; i++) begin : g_cell
        logic [3:0] shift_src;

        if (i == 0) begin : g_first
            assign shift_src = 4'd0;
        end else begin : g_rest
            assign shift_src = digits[i-1];
        end

        sitda_cell u_cell (
            .aclk      (aclk),
            .op        (op),
            .carry_in  (carry[i]),
            .shift_in  (shift_src),
            .carry_out (carry[i+1]),
            .digit     (digits[i])
        );
    end

    // Highest nonzero digit; zero value maps to index 0
    always_comb begin
        top_idx = '0;
        for (int i = 0; i < NDIG; i++) begin
            if (digits[i] != 4'd0) begin
                top_idx = IDXW'(i);
            end
        end
    end

endmodule

// File: rtl/core/signed_int_to_decimal_ascii.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// Converts one VALUE_WIDTH-bit two's-complement integer per request into its
// decimal ASCII text, most significant character first, one character per
// output request, with m_last_char set on the final one. Negative values get
// a leading '-', zero prints as "0", no leading zeros, and the most negative
// value prints in full. One value is in flight at a time: after s_value is
// taken, a row of BCD digit cells absorbs the magnitude four bits per clock,
// a scan state then finds the leading digit, and characters leave at one per
// cycle while m_ready is high.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii #(
    parameter int VALUE_WIDTH = sitda_pkg::VALUE_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [VALUE_WIDTH-1:0] s_value,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [6:0]                    m_char_code,
    output logic                          m_last_char
);

    localparam int BPS    = sitda_pkg::BITS_PER_STEP;
    localparam int NDIG   = sitda_pkg::num_digits(VALUE_WIDTH);
    localparam int IDXW   = $clog2(NDIG);
    localparam int STEPS  = (VALUE_WIDTH + BPS - 1) / BPS;
    localparam int PAD_W  = STEPS * BPS;
    localparam int STEP_W = (STEPS > 1) ? $clog2(STEPS) : 1;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_CONV = 5'b00010,
        ST_SCAN = 5'b00100,
        ST_SIGN = 5'b01000,
        ST_EMIT = 5'b10000
    } state_t;

    state_t                  state_reg, state_next;
    logic [PAD_W-1:0]        mag_reg, mag_next;
    logic [STEP_W-1:0]       step_reg, step_next;
    logic                    neg_reg, neg_next;
    logic [IDXW-1:0]         top_reg, top_next;
    logic [IDXW-1:0]         rem_reg, rem_next;
    logic [VALUE_WIDTH-1:0]  abs_val;
    sitda_pkg::cell_op_t     cell_op;
    logic [NDIG-1:0][3:0]    digits;
    logic [IDXW-1:0]         scan_idx;

    // Unsigned magnitude; the most negative value maps to 2^(W-1)
    assign abs_val = s_value[VALUE_WIDTH-1] ? (~s_value + 1'b1) : s_value;

    sitda_chain #(
        .NDIG (NDIG),
        .IDXW (IDXW)
    ) u_chain (
        .aclk    (aclk),
        .op      (cell_op),
        .bits_in (mag_reg[PAD_W-1 -: BPS]),
        .digits  (digits),
        .top_idx (scan_idx)
    );

    assign s_ready     = (state_reg == ST_IDLE);
    assign m_valid     = (state_reg == ST_SIGN) || (state_reg == ST_EMIT);
    assign m_char_code = (state_reg == ST_SIGN) ? sitda_pkg::ASCII_MINUS
                       : sitda_pkg::ASCII_ZERO + {3'd0, digits[top_reg]};
    assign m_last_char = (state_reg == ST_EMIT) && (rem_reg == '0);

    always_comb begin
        state_next = state_reg;
        mag_next   = mag_reg;
        step_next  = step_reg;
        neg_next   = neg_reg;
        top_next   = top_reg;
        rem_next   = rem_reg;
        cell_op    = sitda_pkg::OP_HOLD;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    mag_next   = PAD_W'(abs_val);
                    neg_next   = s_value[VALUE_WIDTH-1];
                    step_next  = '0;
                    cell_op    = sitda_pkg::OP_CLEAR;
                    state_next = ST_CONV;
                end
            end
            ST_CONV: begin
                cell_op  = sitda_pkg::OP_CONV;
                mag_next = mag_reg << BPS;
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(STEPS - 1)) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                top_next   = scan_idx;
                rem_next   = scan_idx;
                state_next = neg_reg ? ST_SIGN : ST_EMIT;
            end
            ST_SIGN: begin
                if (m_ready) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (m_ready) begin
                    if (rem_reg == '0) begin
                        state_next = ST_IDLE;
                    end else begin
                        // next lower digit moves up into the read slot
                        cell_op  = sitda_pkg::OP_SHIFT;
                        rem_next = rem_reg - 1'b1;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        mag_reg  <= mag_next;
        step_reg <= step_next;
        neg_reg  <= neg_next;
        top_reg  <= top_next;
        rem_reg  <= rem_next;
    end

endmodule

// File: rtl/core/sitda_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sitda_checker
// Port-level checks for the decimal ASCII converter, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sitda_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [6:0] m_char_code,
    input logic       m_last_char
);

    // Only '-' or a digit ever leaves
    `ASSERT_IMPLY(a_char_legal, aclk, aresetn, m_valid, (m_char_code == sitda_pkg::ASCII_MINUS) || ((m_char_code >= sitda_pkg::ASCII_ZERO) && (m_char_code <= sitda_pkg::ASCII_NINE)))

    // The sign is never the whole text
    `ASSERT_IMPLY(a_minus_not_last, aclk, aresetn, m_valid && (m_char_code == sitda_pkg::ASCII_MINUS), !m_last_char)

    // No request taken while a number's text is still going out
    `ASSERT_IMPLY(a_one_in_flight, aclk, aresetn, m_valid, !s_ready)

    // A negative number has no leading zero
    `ASSERT_NEXT(a_no_minus_zero, aclk, aresetn, m_valid && m_ready && (m_char_code == sitda_pkg::ASCII_MINUS), m_valid && (m_char_code != sitda_pkg::ASCII_ZERO))

    // Stalled output request holds
    `ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_char_code) && $stable(m_last_char))

endmodule

bind signed_int_to_decimal_ascii sitda_checker u_sitda_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_char_code (m_char_code),
    .m_last_char (m_last_char)
);
